### rtl/ltsp_pkg.sv
// ----------------------------------------------------------------------------
// ltsp_pkg: shared types and constants of the LLDP TLV stream parser
// Field codes, TLV type codes, organization identifiers and the result word.
// ----------------------------------------------------------------------------
package ltsp_pkg;

    localparam int MAX_TLV_BYTES = 511;

    // header split
    localparam logic [15:0] TLV_TYPE_MASK = 16'hFE00;
    localparam logic [15:0] TLV_LEN_MASK  = 16'h01FF;

    // TLV types
    localparam logic [6:0] TYPE_END     = 7'd0;
    localparam logic [6:0] TYPE_CHASSIS = 7'd1;
    localparam logic [6:0] TYPE_PORT    = 7'd2;
    localparam logic [6:0] TYPE_TTL     = 7'd3;
    localparam logic [6:0] TYPE_ORG     = 7'd127;

    // organization identifiers
    localparam logic [23:0] OUI_PNIO    = {8'h00, 8'h0e, 8'hcf};
    localparam logic [23:0] OUI_IEEE    = {8'h00, 8'h12, 8'h0f};

    localparam logic [1:0] OUI_NONE  = 2'd0;
    localparam logic [1:0] OUI_KPNIO = 2'd1;
    localparam logic [1:0] OUI_KIEEE = 2'd2;
    localparam logic [1:0] OUI_OTHER = 2'd3;

    // organization subtypes
    localparam logic [7:0] PNIO_SUB_DELAY  = 8'd1;
    localparam logic [7:0] PNIO_SUB_STATUS = 8'd2;
    localparam logic [7:0] PNIO_SUB_MAC    = 8'd5;
    localparam logic [7:0] IEEE_SUB_MACPHY = 8'd1;

    // expected TLV lengths of the known organization subtypes
    localparam logic [8:0] LEN_PNIO_DELAY  = 9'd24;
    localparam logic [8:0] LEN_PNIO_STATUS = 9'd8;
    localparam logic [8:0] LEN_PNIO_MAC    = 9'd10;
    localparam logic [8:0] LEN_IEEE_MACPHY = 9'd9;

    // result field codes
    localparam logic [3:0] CODE_CHASSIS_SUB  = 4'd0;
    localparam logic [3:0] CODE_CHASSIS_BYTE = 4'd1;
    localparam logic [3:0] CODE_PORT_SUB     = 4'd2;
    localparam logic [3:0] CODE_PORT_BYTE    = 4'd3;
    localparam logic [3:0] CODE_TTL          = 4'd4;
    localparam logic [3:0] CODE_RX_LOCAL     = 4'd5;
    localparam logic [3:0] CODE_PORT_STATUS  = 4'd10;
    localparam logic [3:0] CODE_CHASSIS_MAC  = 4'd11;
    localparam logic [3:0] CODE_ANEG_STATUS  = 4'd12;
    localparam logic [3:0] CODE_ANEG_CAP     = 4'd13;
    localparam logic [3:0] CODE_MAU          = 4'd14;
    localparam logic [3:0] CODE_DONE         = 4'd15;

    localparam logic [8:0] LIMIT_RESET = 9'd241;

    // result queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [3:0]  code;
        logic [47:0] value;
        logic [8:0]  position;
        logic        status;
        logic        eop;
    } ltsp_item_t;

endpackage

### rtl/lldp_tlv_stream_parser.sv
// ----------------------------------------------------------------------------
// lldp_tlv_stream_parser: LLDP PDU byte stream to decoded TLV fields
// Walks TLV headers and emits ID bytes, TTL, delays, status and MAC/PHY fields.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one PDU byte per word, s_tlast on the final byte of the buffer.
//   m_ channel: one decoded field per word; m_tlast marks the done word that
//   closes a PDU, with the error flag in m_tdata.
//   APB port: register 0 (0x0) chassis ID length limit, register 1 (0x4) port
//   ID length limit, 9 bits each, both 241 after reset.
// Timing:
//   One byte accepted per cycle. The parser state updates at the accept edge
//   and the byte's results enter a 4-word result queue in the same edge, and m_
//   is driven from the head of that registered queue. A byte gives at
//   most two words (a field and a trailing error done); s_tready stays high
//   while the queue has room for two words, so a byte per cycle is sustained
//   as long as the sink takes a word per cycle.
// Reset: clears the parser to the first header byte and empties the queue.
// Stall: while m_tready is low the queue fills and then s_tready drops; no
//   word is lost or repeated.
// ----------------------------------------------------------------------------
module lldp_tlv_stream_parser
    import ltsp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    // decoded fields
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [47:0] field_value, [56:48] position,
                                   // [57] parse_status, [63:58] zero
    output logic [3:0]  m_tuser,   // [3:0] field_code
    output logic        m_tlast,   // end_of_pdu
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [2:0] PH_HDR0   = 3'd0;
    localparam logic [2:0] PH_HDR1   = 3'd1;
    localparam logic [2:0] PH_ID     = 3'd2;
    localparam logic [2:0] PH_TTL    = 3'd3;
    localparam logic [2:0] PH_ORG    = 3'd4;
    localparam logic [2:0] PH_FIELDS = 3'd5;
    localparam logic [2:0] PH_SKIP   = 3'd6;
    localparam logic [2:0] PH_DONE   = 3'd7;

    // configuration
    logic [8:0] chassis_limit_reg;
    logic [8:0] port_limit_reg;
    logic       cfg_write;

    // parser state
    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  header_high_reg, header_high_next;
    logic [6:0]  tlv_type_reg, tlv_type_next;
    logic [8:0]  tlv_length_reg, tlv_length_next;
    logic [8:0]  byte_cnt_reg, byte_cnt_next;
    logic [47:0] value_reg, value_next;
    logic [1:0]  oui_kind_reg, oui_kind_next;
    logic [7:0]  org_sub_reg, org_sub_next;
    logic        finished_reg, finished_next;

    // result queue
    ltsp_item_t        queue_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    // per-byte decode
    logic        accept;
    logic        pop;
    logic [7:0]  b;
    logic [15:0] hdr;
    logic [6:0]  hdr_type;
    logic [8:0]  hdr_len;
    logic [8:0]  id_limit;
    logic [8:0]  byte_inc;
    logic [8:0]  field_pos;
    logic [8:0]  need_len;
    logic [47:0] shifted;
    logic        fin_now;
    logic        fin_err;
    logic        item_a_valid;
    logic        item_b_valid;
    ltsp_item_t  item_a;
    ltsp_item_t  item_b;
    logic [1:0]  push_cnt;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = paddr[2] ? {23'd0, port_limit_reg} : {23'd0, chassis_limit_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chassis_limit_reg <= LIMIT_RESET;
            port_limit_reg    <= LIMIT_RESET;
        end else if (cfg_write) begin
            if (paddr[2]) begin
                port_limit_reg <= pwdata[8:0];
            end else begin
                chassis_limit_reg <= pwdata[8:0];
            end
        end
    end

    assign s_tready = (count_reg <= QCNT_W'(QDEPTH - 2));
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = (count_reg != '0);
    assign pop      = m_tvalid && m_tready;

    assign b        = s_tdata;
    assign hdr      = {header_high_reg, b};
    assign hdr_type = 7'((hdr & TLV_TYPE_MASK) >> 9);
    assign hdr_len  = 9'(hdr & TLV_LEN_MASK);
    assign id_limit = (hdr_type == TYPE_CHASSIS) ? chassis_limit_reg : port_limit_reg;
    assign byte_inc = byte_cnt_reg + 9'd1;
    assign field_pos = byte_cnt_reg - 9'd4;
    assign shifted  = {value_reg[39:0], b};

    always_comb begin
        phase_next       = phase_reg;
        header_high_next = header_high_reg;
        tlv_type_next    = tlv_type_reg;
        tlv_length_next  = tlv_length_reg;
        byte_cnt_next    = byte_cnt_reg;
        value_next       = value_reg;
        oui_kind_next    = oui_kind_reg;
        org_sub_next     = org_sub_reg;
        finished_next    = finished_reg;
        fin_now          = 1'b0;
        fin_err          = 1'b0;
        item_a_valid     = 1'b0;
        item_a           = '0;
        item_b           = '0;
        item_b_valid     = 1'b0;
        need_len         = '0;

        if (accept) begin
            unique case (phase_reg)
                PH_HDR0: begin
                    header_high_next = b;
                    phase_next       = PH_HDR1;
                end
                PH_HDR1: begin
                    tlv_type_next   = hdr_type;
                    tlv_length_next = hdr_len;
                    value_next      = '0;
                    oui_kind_next   = OUI_NONE;
                    org_sub_next    = '0;
                    if (hdr_type == TYPE_END) begin
                        fin_now = 1'b1;
                    end else if ({1'b0, hdr_len} > 10'(MAX_TLV_BYTES)) begin
                        fin_now = 1'b1;
                        fin_err = 1'b1;
                    end else if (hdr_type == TYPE_CHASSIS || hdr_type == TYPE_PORT) begin
                        byte_cnt_next = '0;
                        if (hdr_len != 9'd0 && (hdr_len - 9'd1) < id_limit) begin
                            phase_next = PH_ID;
                        end else begin
                            phase_next = (hdr_len == 9'd0) ? PH_HDR0 : PH_SKIP;
                        end
                    end else if (hdr_type == TYPE_TTL) begin
                        if (hdr_len == 9'd2) begin
                            byte_cnt_next = '0;
                            phase_next    = PH_TTL;
                        end else begin
                            fin_now = 1'b1;
                            fin_err = 1'b1;
                        end
                    end else if (hdr_type == TYPE_ORG) begin
                        if (hdr_len < 9'd4) begin
                            fin_now = 1'b1;
                            fin_err = 1'b1;
                        end else begin
                            byte_cnt_next = '0;
                            phase_next    = PH_ORG;
                        end
                    end else begin
                        byte_cnt_next = '0;
                        phase_next    = (hdr_len == 9'd0) ? PH_HDR0 : PH_SKIP;
                    end
                end
                PH_ID: begin
                    item_a_valid = 1'b1;
                    item_a.value = {40'd0, b};
                    if (byte_cnt_reg == 9'd0) begin
                        item_a.code     = (tlv_type_reg == TYPE_CHASSIS) ?
                                          CODE_CHASSIS_SUB : CODE_PORT_SUB;
                        item_a.position = tlv_length_reg - 9'd1;
                    end else begin
                        item_a.code     = (tlv_type_reg == TYPE_CHASSIS) ?
                                          CODE_CHASSIS_BYTE : CODE_PORT_BYTE;
                        item_a.position = byte_cnt_reg - 9'd1;
                    end
                    byte_cnt_next = byte_inc;
                    if (byte_inc >= tlv_length_reg) begin
                        phase_next = PH_HDR0;
                    end
                end
                PH_TTL: begin
                    byte_cnt_next = byte_inc;
                    if (byte_inc >= 9'd2) begin
                        item_a_valid = 1'b1;
                        item_a.code  = CODE_TTL;
                        item_a.value = {32'd0, value_reg[7:0], b};
                        value_next   = '0;
                        phase_next   = PH_HDR0;
                    end else begin
                        value_next = {32'd0, value_reg[7:0], b};
                    end
                end
                PH_ORG: begin
                    if (byte_cnt_reg < 9'd3) begin
                        value_next    = {24'd0, value_reg[15:0], b};
                        byte_cnt_next = byte_inc;
                    end else begin
                        org_sub_next = b;
                        value_next   = '0;
                        if (value_reg[23:0] == OUI_PNIO) begin
                            oui_kind_next = OUI_KPNIO;
                            unique case (b)
                                PNIO_SUB_DELAY:  need_len = LEN_PNIO_DELAY;
                                PNIO_SUB_STATUS: need_len = LEN_PNIO_STATUS;
                                PNIO_SUB_MAC:    need_len = LEN_PNIO_MAC;
                                default:         need_len = '0;
                            endcase
                        end else if (value_reg[23:0] == OUI_IEEE) begin
                            oui_kind_next = OUI_KIEEE;
                            need_len = (b == IEEE_SUB_MACPHY) ? LEN_IEEE_MACPHY : 9'd0;
                        end else begin
                            oui_kind_next = OUI_OTHER;
                        end
                        if (need_len == 9'd0) begin
                            byte_cnt_next = 9'd4;
                            phase_next = (tlv_length_reg <= 9'd4) ? PH_HDR0 : PH_SKIP;
                        end else if (tlv_length_reg != need_len) begin
                            fin_now = 1'b1;
                            fin_err = 1'b1;
                        end else begin
                            byte_cnt_next = 9'd4;
                            phase_next    = PH_FIELDS;
                        end
                    end
                end
                PH_FIELDS: begin
                    if (oui_kind_reg == OUI_KPNIO && org_sub_reg == PNIO_SUB_DELAY) begin
                        item_a_valid = (field_pos[1:0] == 2'd3);
                        item_a.code  = CODE_RX_LOCAL + {1'b0, field_pos[4:2]};
                    end else if (oui_kind_reg == OUI_KPNIO &&
                                 org_sub_reg == PNIO_SUB_STATUS) begin
                        item_a_valid = (field_pos == 9'd3);
                        item_a.code  = CODE_PORT_STATUS;
                    end else if (oui_kind_reg == OUI_KPNIO && org_sub_reg == PNIO_SUB_MAC) begin
                        item_a_valid = (field_pos == 9'd5);
                        item_a.code  = CODE_CHASSIS_MAC;
                    end else begin
                        item_a_valid = (field_pos == 9'd0) || (field_pos == 9'd2) ||
                                       (field_pos == 9'd4);
                        if (field_pos == 9'd0) begin
                            item_a.code = CODE_ANEG_STATUS;
                        end else if (field_pos == 9'd2) begin
                            item_a.code = CODE_ANEG_CAP;
                        end else begin
                            item_a.code = CODE_MAU;
                        end
                    end
                    item_a.value = shifted;
                    value_next   = item_a_valid ? 48'd0 : shifted;
                    byte_cnt_next = byte_inc;
                    if (byte_inc >= tlv_length_reg) begin
                        phase_next = PH_HDR0;
                    end
                end
                PH_SKIP: begin
                    byte_cnt_next = byte_inc;
                    if (byte_inc >= tlv_length_reg) begin
                        phase_next = PH_HDR0;
                    end
                end
                PH_DONE: begin
                end
                default: begin
                end
            endcase

            if (fin_now) begin
                phase_next    = PH_DONE;
                finished_next = 1'b1;
                item_a_valid  = 1'b1;
                item_a        = '{code: CODE_DONE, value: '0, position: '0,
                                  status: fin_err, eop: 1'b1};
            end

            // truncated buffer: close the PDU with an error, then start over
            item_b_valid = s_tlast && !finished_reg && !fin_now;
            item_b       = '{code: CODE_DONE, value: '0, position: '0,
                             status: 1'b1, eop: 1'b1};
            if (s_tlast) begin
                phase_next       = PH_HDR0;
                header_high_next = '0;
                tlv_type_next    = '0;
                tlv_length_next  = '0;
                byte_cnt_next    = '0;
                value_next       = '0;
                oui_kind_next    = OUI_NONE;
                org_sub_next     = '0;
                finished_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_HDR0;
            header_high_reg <= '0;
            tlv_type_reg    <= '0;
            tlv_length_reg  <= '0;
            byte_cnt_reg    <= '0;
            value_reg       <= '0;
            oui_kind_reg    <= OUI_NONE;
            org_sub_reg     <= '0;
            finished_reg    <= 1'b0;
        end else begin
            phase_reg       <= phase_next;
            header_high_reg <= header_high_next;
            tlv_type_reg    <= tlv_type_next;
            tlv_length_reg  <= tlv_length_next;
            byte_cnt_reg    <= byte_cnt_next;
            value_reg       <= value_next;
            oui_kind_reg    <= oui_kind_next;
            org_sub_reg     <= org_sub_next;
            finished_reg    <= finished_next;
        end
    end

    // result queue: up to two words in, one word out per cycle
    assign push_cnt = {1'b0, item_a_valid} + {1'b0, item_b_valid};

    always_ff @(posedge aclk) begin
        if (item_a_valid) begin
            queue_reg[wr_ptr_reg] <= item_a;
        end
        if (item_b_valid) begin
            queue_reg[wr_ptr_reg + QPTR_W'(item_a_valid)] <= item_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + QPTR_W'(push_cnt);
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_reg + QCNT_W'(push_cnt) - QCNT_W'(pop);
        end
    end

    assign m_tdata = {6'd0, queue_reg[rd_ptr_reg].status, queue_reg[rd_ptr_reg].position,
                      queue_reg[rd_ptr_reg].value};
    assign m_tuser = queue_reg[rd_ptr_reg].code;
    assign m_tlast = queue_reg[rd_ptr_reg].eop;

    // queue never overflows
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("result queue overflow");

    // words pushed always fit in the free room
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push_cnt != 2'd0) |-> ({1'b0, count_reg} + {2'd0, push_cnt} <= (QCNT_W+1)'(QDEPTH)))
        else $error("push without room");

    // final buffer byte always restarts the parser
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tlast) |=> (phase_reg == PH_HDR0 && !finished_reg))
        else $error("parser not restarted after last byte");

    // end of PDU only on done words
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tuser == CODE_DONE))
        else $error("end of PDU on a non-done word");

    // done state is entered only together with a done word
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_next == PH_DONE && phase_reg != PH_DONE) |-> (item_a_valid && item_a.eop))
        else $error("done state without done word");

endmodule

### sim/ltsp_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltsp_tb_pkg: register map of the LLDP TLV parser bench
// APB byte addresses shared by the stimulus and the field checker.
// ----------------------------------------------------------------------------
package ltsp_tb_pkg;

    localparam logic [2:0] ADDR_CHASSIS_LIMIT = 3'h0;
    localparam logic [2:0] ADDR_PORT_LIMIT    = 3'h4;

endpackage

### sim/ltsp_field_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltsp_field_checker: decoded-field predictor and scoreboard
// Watches the byte, field and APB channels, walks each accepted byte through
// its own TLV parser and compares every field word with the oldest prediction.
// ----------------------------------------------------------------------------
module ltsp_field_checker
    import ltsp_pkg::*;
    import ltsp_tb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic [3:0]  m_tuser,
    input  logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatches,
    output int          pending
);

    typedef enum logic [3:0] {
        ST_HDR_HI, ST_HDR_LO, ST_ID, ST_TTL, ST_OUI, ST_FIELDS, ST_SKIP, ST_DONE
    } walk_state_t;

    walk_state_t  walk;
    logic [7:0]   hdr_hi;
    logic [6:0]   tlv_kind;
    logic [8:0]   tlv_len;
    int           tlv_idx;
    logic [47:0]  shift_acc;
    logic [1:0]   org_kind;
    logic [7:0]   org_sub;
    logic         err_flag;
    logic         finished;
    logic [8:0]   chassis_limit;
    logic [8:0]   port_limit;
    ltsp_item_t   expected_fields[$];
    int           err_count = 0;

    task automatic push_field(input logic [3:0] code, input logic [47:0] value,
                              input logic [8:0] pos, input logic status,
                              input logic eop);
        ltsp_item_t it;
        it.code     = code;
        it.value    = value;
        it.position = pos;
        it.status   = status;
        it.eop      = eop;
        expected_fields.push_back(it);
    endtask

    task automatic close_pdu(input logic err);
        err_flag = err;
        finished = 1'b1;
        walk     = ST_DONE;
        push_field(CODE_DONE, '0, '0, err, 1'b1);
    endtask

    task automatic clear_walk();
        walk      = ST_HDR_HI;
        hdr_hi    = '0;
        tlv_kind  = '0;
        tlv_len   = '0;
        tlv_idx   = 0;
        shift_acc = '0;
        org_kind  = OUI_NONE;
        org_sub   = '0;
        err_flag  = 1'b0;
        finished  = 1'b0;
    endtask

    task automatic skip_from(input int from);
        tlv_idx = from;
        walk    = (from >= int'(tlv_len)) ? ST_HDR_HI : ST_SKIP;
    endtask

    task automatic take_header(input logic [7:0] lo);
        logic [15:0] h;
        int          lim;
        h         = {hdr_hi, lo};
        tlv_kind  = 7'((h & TLV_TYPE_MASK) >> 9);
        tlv_len   = 9'(h & TLV_LEN_MASK);
        shift_acc = '0;
        org_kind  = OUI_NONE;
        org_sub   = '0;
        if (tlv_kind == TYPE_END) begin
            close_pdu(1'b0);
        end else if (int'(tlv_len) > MAX_TLV_BYTES) begin
            close_pdu(1'b1);
        end else if (tlv_kind == TYPE_CHASSIS || tlv_kind == TYPE_PORT) begin
            lim = (tlv_kind == TYPE_CHASSIS) ? int'(chassis_limit) : int'(port_limit);
            if (tlv_len >= 9'd1 && int'(tlv_len) - 1 < lim) begin
                tlv_idx = 0;
                walk    = ST_ID;
            end else begin
                skip_from(0);
            end
        end else if (tlv_kind == TYPE_TTL) begin
            if (tlv_len == 9'd2) begin
                tlv_idx = 0;
                walk    = ST_TTL;
            end else begin
                close_pdu(1'b1);
            end
        end else if (tlv_kind == TYPE_ORG) begin
            if (tlv_len < 9'd4) begin
                close_pdu(1'b1);
            end else begin
                tlv_idx = 0;
                walk    = ST_OUI;
            end
        end else begin
            skip_from(0);
        end
    endtask

    // Classify the OUI and subtype once the fourth body byte is in.
    task automatic decide_org();
        int need;
        need = 0;
        if (shift_acc == 48'(OUI_PNIO)) begin
            org_kind = OUI_KPNIO;
            if (org_sub == PNIO_SUB_DELAY)       need = int'(LEN_PNIO_DELAY);
            else if (org_sub == PNIO_SUB_STATUS) need = int'(LEN_PNIO_STATUS);
            else if (org_sub == PNIO_SUB_MAC)    need = int'(LEN_PNIO_MAC);
        end else if (shift_acc == 48'(OUI_IEEE)) begin
            org_kind = OUI_KIEEE;
            if (org_sub == IEEE_SUB_MACPHY) need = int'(LEN_IEEE_MACPHY);
        end else begin
            org_kind = OUI_OTHER;
        end
        shift_acc = '0;
        if (need == 0) begin
            skip_from(4);
        end else if (int'(tlv_len) != need) begin
            close_pdu(1'b1);
        end else begin
            tlv_idx = 4;
            walk    = ST_FIELDS;
        end
    endtask

    task automatic field_byte(input logic [7:0] b);
        int         p;
        logic       ends;
        logic [3:0] code;
        p         = tlv_idx - 4;
        ends      = 1'b0;
        code      = '0;
        shift_acc = {shift_acc[39:0], b};
        if (org_kind == OUI_KPNIO && org_sub == PNIO_SUB_DELAY) begin
            if ((p & 3) == 3) begin
                ends = 1'b1;
                code = 4'(int'(CODE_RX_LOCAL) + (p >> 2));
            end
        end else if (org_kind == OUI_KPNIO && org_sub == PNIO_SUB_STATUS) begin
            if (p == 3) begin
                ends = 1'b1;
                code = CODE_PORT_STATUS;
            end
        end else if (org_kind == OUI_KPNIO && org_sub == PNIO_SUB_MAC) begin
            if (p == 5) begin
                ends = 1'b1;
                code = CODE_CHASSIS_MAC;
            end
        end else begin
            if (p == 0) begin
                ends = 1'b1;
                code = CODE_ANEG_STATUS;
            end else if (p == 2) begin
                ends = 1'b1;
                code = CODE_ANEG_CAP;
            end else if (p == 4) begin
                ends = 1'b1;
                code = CODE_MAU;
            end
        end
        if (ends) begin
            push_field(code, shift_acc, '0, 1'b0, 1'b0);
            shift_acc = '0;
        end
        tlv_idx++;
        if (tlv_idx >= int'(tlv_len)) walk = ST_HDR_HI;
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic last);
        logic [3:0] base;
        case (walk)
            ST_HDR_HI: begin
                hdr_hi = b;
                walk   = ST_HDR_LO;
            end
            ST_HDR_LO: take_header(b);
            ST_ID: begin
                base = (tlv_kind == TYPE_CHASSIS) ? CODE_CHASSIS_SUB : CODE_PORT_SUB;
                if (tlv_idx == 0) begin
                    push_field(base, 48'(b), tlv_len - 9'd1, 1'b0, 1'b0);
                end else begin
                    push_field((base == CODE_CHASSIS_SUB) ? CODE_CHASSIS_BYTE
                                                          : CODE_PORT_BYTE,
                               48'(b), 9'(tlv_idx - 1), 1'b0, 1'b0);
                end
                tlv_idx++;
                if (tlv_idx >= int'(tlv_len)) walk = ST_HDR_HI;
            end
            ST_TTL: begin
                shift_acc = {32'd0, shift_acc[7:0], b};
                tlv_idx++;
                if (tlv_idx >= 2) begin
                    push_field(CODE_TTL, shift_acc, '0, 1'b0, 1'b0);
                    shift_acc = '0;
                    walk      = ST_HDR_HI;
                end
            end
            ST_OUI: begin
                if (tlv_idx < 3) begin
                    shift_acc = {24'd0, shift_acc[15:0], b};
                    tlv_idx++;
                end else begin
                    org_sub = b;
                    decide_org();
                end
            end
            ST_FIELDS: field_byte(b);
            ST_SKIP: begin
                tlv_idx++;
                if (tlv_idx >= int'(tlv_len)) walk = ST_HDR_HI;
            end
            default: ;
        endcase
        // end of buffer: flag truncation, then rearm for the next PDU
        if (last) begin
            if (!finished) close_pdu(1'b1);
            clear_walk();
        end
    endtask

    task automatic check_field(input string name, input logic [47:0] want,
                               input logic [47:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_count++;
        end
    endtask

    always @(posedge aclk) begin
        ltsp_item_t want;
        if (!aresetn) begin
            clear_walk();
            chassis_limit = LIMIT_RESET;
            port_limit    = LIMIT_RESET;
            expected_fields.delete();
        end else begin
            // compare first: a word leaving now came from an earlier byte
            if (m_tvalid && m_tready) begin
                if (expected_fields.size() == 0) begin
                    $error("unexpected word: code 0x%0h, data 0x%0h, last %0b",
                           m_tuser, m_tdata, m_tlast);
                    err_count++;
                end else begin
                    want = expected_fields.pop_front();
                    check_field("field_code", 48'(want.code), 48'(m_tuser));
                    check_field("field_value", want.value, m_tdata[47:0]);
                    check_field("position", 48'(want.position), 48'(m_tdata[56:48]));
                    check_field("parse_status", 48'(want.status), 48'(m_tdata[57]));
                    check_field("end_of_pdu", 48'(want.eop), 48'(m_tlast));
                end
            end
            if (psel && penable && pwrite && pready) begin
                if (paddr == ADDR_CHASSIS_LIMIT)   chassis_limit = pwdata[8:0];
                else if (paddr == ADDR_PORT_LIMIT) port_limit    = pwdata[8:0];
            end
            if (s_tvalid && s_tready) predict_byte(s_tdata, s_tlast);
        end
        mismatches <= err_count;
        pending    <= expected_fields.size();
    end

endmodule

### sim/lldp_tlv_stream_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lldp_tlv_stream_parser_tb: bench for the LLDP TLV stream parser
// Feeds directed and random LLDP PDUs (well-formed, truncated, malformed and
// noise) under bursty input and a stalling sink, over several ID-length limit
// settings; the field checker beside the parser predicts and scores each word.
// ----------------------------------------------------------------------------
module lldp_tlv_stream_parser_tb;
    import ltsp_pkg::*;
    import ltsp_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int PHASE_BYTES  = 275;

    typedef enum logic [1:0] {SINK_STEADY, SINK_LIGHT, SINK_HEAVY} sink_mode_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int          mismatches;
    int          pending;
    int          cycle_count = 0;
    int          bytes_sent  = 0;
    int          burst_left  = 0;
    int          gap_max     = 0;
    int          sink_hold   = 0;
    sink_mode_t  sink_mode   = SINK_STEADY;
    int          cur_chassis_limit = int'(LIMIT_RESET);
    int          cur_port_limit    = int'(LIMIT_RESET);
    logic [7:0]  pdu_q[$];

    lldp_tlv_stream_parser u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    ltsp_field_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("lldp_tlv_stream_parser_tb: FAIL");
            $finish;
        end
    end

    // sink: hold off for random stretches, never in steady mode
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            sink_hold <= 0;
        end else if (sink_hold != 0) begin
            m_tready  <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else if (sink_mode != SINK_STEADY && $urandom_range(0, 99) < 25) begin
            m_tready  <= 1'b0;
            sink_hold <= (sink_mode == SINK_HEAVY) ? $urandom_range(0, 19)
                                                   : $urandom_range(0, 2);
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_queue();
        foreach (pdu_q[i]) send_byte(pdu_q[i], i == pdu_q.size() - 1);
    endtask

    // stop sending until every predicted word has left the parser
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    task automatic apb_write(input logic [2:0] addr, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_limits(input int chassis, input int port);
        drain_results();
        repeat (4) @(posedge aclk);
        apb_write(ADDR_CHASSIS_LIMIT, chassis);
        apb_write(ADDR_PORT_LIMIT, port);
        cur_chassis_limit = chassis;
        cur_port_limit    = port;
    endtask

    task automatic add_header(input logic [6:0] kind, input int len);
        logic [15:0] h;
        h = {kind, 9'(len)};
        pdu_q.push_back(h[15:8]);
        pdu_q.push_back(h[7:0]);
    endtask

    task automatic add_bytes(input int n);
        repeat (n) pdu_q.push_back(rand_byte());
    endtask

    task automatic add_org(input logic [23:0] oui, input logic [7:0] sub, input int len);
        add_header(TYPE_ORG, len);
        if (len >= 4) begin
            pdu_q.push_back(oui[23:16]);
            pdu_q.push_back(oui[15:8]);
            pdu_q.push_back(oui[7:0]);
            pdu_q.push_back(sub);
            add_bytes(len - 4);
        end else begin
            add_bytes(len);
        end
    endtask

    task automatic add_known_org(input logic [23:0] oui, input logic [7:0] sub,
                                 input int need);
        int len;
        len = need;
        if ($urandom_range(0, 9) == 0) begin
            len = $urandom_range(4, need + 4);
            if (len == need) len++;
        end
        add_org(oui, sub, len);
    endtask

    // mostly short IDs; lengths around the limit where it is small, rarely huge
    function automatic int pick_id_len(input int lim);
        int r;
        r = $urandom_range(0, 399);
        if (r < 12)               return 0;
        if (r == 12)              return $urandom_range(200, 511);
        if (r < 15 && lim > 16)   return lim + $urandom_range(0, 1);
        if (r < 120 && lim <= 16) return lim + $urandom_range(0, 2);
        return $urandom_range(1, 12);
    endfunction

    task automatic add_id(input logic [6:0] kind);
        int len;
        len = pick_id_len((kind == TYPE_CHASSIS) ? cur_chassis_limit : cur_port_limit);
        add_header(kind, len);
        add_bytes(len);
    endtask

    task automatic add_random_tlv();
        int pick;
        int r;
        pick = $urandom_range(0, 23);
        if (pick <= 2) begin
            add_id($urandom_range(0, 1) ? TYPE_CHASSIS : TYPE_PORT);
        end else if (pick <= 4) begin
            add_header(TYPE_TTL, 2);
            add_bytes(2);
        end else if (pick == 5) begin
            r = $urandom_range(0, 3);
            add_header(TYPE_TTL, (r < 2) ? r : r + 1);
            add_bytes((r < 2) ? r : r + 1);
        end else if (pick <= 8) begin
            add_known_org(OUI_PNIO, PNIO_SUB_DELAY, int'(LEN_PNIO_DELAY));
        end else if (pick <= 10) begin
            add_known_org(OUI_PNIO, PNIO_SUB_STATUS, int'(LEN_PNIO_STATUS));
        end else if (pick <= 12) begin
            add_known_org(OUI_PNIO, PNIO_SUB_MAC, int'(LEN_PNIO_MAC));
        end else if (pick <= 15) begin
            add_known_org(OUI_IEEE, IEEE_SUB_MACPHY, int'(LEN_IEEE_MACPHY));
        end else if (pick <= 17) begin
            r = $urandom_range(0, 2);
            add_org((r == 0) ? OUI_PNIO : (r == 1) ? OUI_IEEE : 24'($urandom),
                    rand_byte(), $urandom_range(4, 12));
        end else if (pick == 18) begin
            add_org(OUI_PNIO, PNIO_SUB_DELAY, $urandom_range(0, 3));
        end else begin
            r = $urandom_range(0, 8);
            add_header(7'($urandom_range(4, 126)), r);
            add_bytes(r);
        end
    endtask

    task automatic send_random_pdu();
        int ending;
        int cut;
        pdu_q.delete();
        if ($urandom_range(0, 14) == 0) begin
            // line noise
            add_bytes($urandom_range(1, 6));
        end else begin
            if ($urandom_range(0, 9) != 0) add_id(TYPE_CHASSIS);
            if ($urandom_range(0, 9) != 0) add_id(TYPE_PORT);
            if ($urandom_range(0, 9) != 0) begin
                add_header(TYPE_TTL, 2);
                add_bytes(2);
            end
            repeat ($urandom_range(0, 4)) add_random_tlv();
            ending = $urandom_range(0, 9);
            if (ending < 8) begin
                add_header(TYPE_END, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : 0);
                add_bytes($urandom_range(0, 2));
            end else if (ending == 8 && pdu_q.size() > 1) begin
                cut = $urandom_range(0, pdu_q.size() - 2);
                pdu_q = pdu_q[0:cut];
            end
            if (pdu_q.size() == 0) add_bytes(1);
        end
        send_queue();
    endtask

    task automatic run_phase(input sink_mode_t sink, input int gaps, input int budget);
        sink_mode = sink;
        gap_max   = gaps;
        while (bytes_sent < budget) send_random_pdu();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: IDs at the shortest lengths, TTL, end TLV with a length,
        // done on the last byte, bad TTL length with ignored tail, short org
        // TLV, and a truncated chassis ID
        sink_mode = SINK_LIGHT;
        pdu_q.delete();
        add_header(TYPE_CHASSIS, 2);
        pdu_q.push_back(8'h07);
        pdu_q.push_back(8'hFF);
        add_header(TYPE_PORT, 1);
        pdu_q.push_back(8'h00);
        add_header(TYPE_TTL, 2);
        pdu_q.push_back(8'hFF);
        pdu_q.push_back(8'hFF);
        add_header(TYPE_END, 5);
        send_queue();
        pdu_q.delete();
        add_header(TYPE_TTL, 3);
        pdu_q.push_back(8'hAA);
        send_queue();
        pdu_q.delete();
        add_header(TYPE_ORG, 3);
        send_queue();
        pdu_q.delete();
        add_header(TYPE_CHASSIS, 3);
        pdu_q.push_back(8'h80);
        send_queue();

        run_phase(SINK_STEADY, 0, bytes_sent + PHASE_BYTES);
        set_limits(1, 1);
        run_phase(SINK_LIGHT, 3, bytes_sent + PHASE_BYTES);
        set_limits(256, 256);
        run_phase(SINK_HEAVY, 6, bytes_sent + PHASE_BYTES);
        set_limits(3, 256);
        run_phase(SINK_LIGHT, 0, bytes_sent + PHASE_BYTES);
        set_limits(256, 7);
        run_phase(SINK_STEADY, 4, bytes_sent + PHASE_BYTES);
        set_limits($urandom_range(1, 256), $urandom_range(1, 256));
        run_phase(SINK_HEAVY, 2, bytes_sent + PHASE_BYTES);

        drain_results();
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("lldp_tlv_stream_parser_tb: PASS");
        end else begin
            $display("lldp_tlv_stream_parser_tb: FAIL");
        end
        $finish;
    end

endmodule
